[rtl/bte_pkg.sv]
// Package for the bucket table engine: table sizes, operation codes, status codes, states.
package bte_pkg;

    localparam int NUM_BUCKETS  = 256;
    localparam int BUCKET_DEPTH = 8;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_CLEAR = 3'd1;
    localparam logic [2:0] OP_COUNT = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_PURGE = 3'd4;
    localparam logic [2:0] OP_CHECK = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_FILL_RD,
        S_FILL_WAIT,
        S_EXEC,
        S_SCAN,
        S_PURGE_RD,
        S_PURGE_WR,
        S_DONE
    } state_t;

endpackage

[rtl/bucket_table_engine.sv]
// Top level of the bucket table engine: state machine, memories and result beat.
//
// Usage: raise start for one cycle with operation, key, value and index while
// busy is low; the beat is taken on that edge and busy rises. When the
// operation completes, done pulses for exactly one cycle with status, count,
// entry_value, hit, bucket and used_count. The receiver cannot stall: the
// result beat is shown once and busy falls in the same cycle.
// The user writes key_count through key_count_we/key_count_wdata only while idle;
// the block itself does not enforce this. Add, clear, count and read pass through
// the fill read, fill wait and execute states. Check takes the bucket modulo (one
// subtract per cycle over the value bits), then reads fill and scans one entry per
// cycle of the entry memory port. Purge walks the used list, one read and one write
// state per listed key, through the single read port of the used-key memory.
// Reset clears fill counts and listed bits through per-bucket valid bits,
// and key_count returns to 256; the entry and used-key memories need no pass.
// One item is in flight at a time.
module bucket_table_engine #(
    parameter int VALUE_BITS   = 31
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            operation,
    input  logic [7:0]            key,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [2:0]            index,
    input  logic                  key_count_we,
    input  logic [8:0]            key_count_wdata,
    output logic                  done,
    output logic [1:0]            status,
    output logic [3:0]            count,
    output logic [VALUE_BITS-1:0] entry_value,
    output logic                  hit,
    output logic [7:0]            bucket,
    output logic [8:0]            used_count
);

    localparam int NUM_BUCKETS  = bte_pkg::NUM_BUCKETS;
    localparam int BUCKET_DEPTH = bte_pkg::BUCKET_DEPTH;
    localparam int BW = $clog2(NUM_BUCKETS);
    localparam int DW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int FW = $clog2(BUCKET_DEPTH + 1);
    localparam int UW = $clog2(NUM_BUCKETS + 1);
    localparam int VCW = $clog2(VALUE_BITS + 1);
    localparam int EW = BW + DW;
    localparam int KW = (BW > 9) ? BW : 9;

    bte_pkg::state_t state_reg, state_next;

    logic [8:0]            kc_reg;
    logic [2:0]            op_reg;
    logic [BW-1:0]         key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [2:0]            idx_reg;
    logic                  krange_reg;
    logic [KW:0]           rem_reg;
    logic [VCW-1:0]        bit_reg;
    logic [FW-1:0]         fill_reg;
    logic [DW:0]           scan_reg;
    logic                  hit_reg;
    logic [UW-1:0]         total_reg;
    logic [UW-1:0]         pidx_reg;

    logic [1:0]            status_reg;
    logic [3:0]            count_reg;
    logic [VALUE_BITS-1:0] ev_reg;
    logic                  hitout_reg;
    logic [7:0]            bucket_reg;
    logic                  done_reg;

    // fill + listed memory, with per-bucket valid bits for reset
    logic [FW:0]           meta_mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] meta_vld_reg;
    logic [FW:0]           meta_q;
    logic                  meta_rv_reg;
    logic [BW-1:0]         meta_ra;
    logic                  meta_we;
    logic [BW-1:0]         meta_wa;
    logic [FW:0]           meta_wd;

    logic [VALUE_BITS-1:0] ent_mem [NUM_BUCKETS*BUCKET_DEPTH];
    logic [VALUE_BITS-1:0] ent_q;
    logic                  ent_we;
    logic [EW-1:0]         ent_wa;
    logic [EW-1:0]         ent_ra;

    logic [BW-1:0]         used_mem [NUM_BUCKETS];
    logic [BW-1:0]         used_q;
    logic                  used_we;

    logic [KW:0]           nb;
    logic [KW:0]           rem_sh;
    logic                  key_in_range;
    logic [FW-1:0]         fill_cur;
    logic                  listed_cur;

    always_comb
    begin
        if (kc_reg == 9'd0)
            nb = (KW+1)'(1);
        else if ({{(KW-8){1'b0}}, kc_reg} > (KW+1)'(NUM_BUCKETS))
            nb = (KW+1)'(NUM_BUCKETS);
        else
            nb = {{(KW-8){1'b0}}, kc_reg};
    end

    assign key_in_range = ({{(KW+1-8){1'b0}}, key} < nb);
    assign rem_sh = {rem_reg[KW-1:0], val_reg[bit_reg - VCW'(1)]};
    assign fill_cur = meta_rv_reg ? meta_q[FW-1:0] : '0;
    assign listed_cur = meta_rv_reg ? meta_q[FW] : 1'b0;

    always_comb
    begin
        meta_ra = key_reg;
        ent_ra = {key_reg, idx_reg[DW-1:0]};
        if (state_reg == bte_pkg::S_SCAN)
            ent_ra = {key_reg, scan_reg[DW-1:0] + DW'(1)};
        else if (state_reg == bte_pkg::S_FILL_WAIT && op_reg == bte_pkg::OP_CHECK)
            ent_ra = {key_reg, {DW{1'b0}}};
    end

    always_comb
    begin
        meta_we = 1'b0;
        meta_wa = key_reg;
        meta_wd = '0;
        ent_we = 1'b0;
        ent_wa = {key_reg, fill_cur[DW-1:0]};
        used_we = 1'b0;
        if (state_reg == bte_pkg::S_EXEC && krange_reg)
        begin
            if (op_reg == bte_pkg::OP_ADD && fill_cur < FW'(BUCKET_DEPTH))
            begin
                meta_we = 1'b1;
                meta_wd = {1'b1, fill_cur + FW'(1)};
                ent_we = 1'b1;
                used_we = !listed_cur && total_reg < UW'(NUM_BUCKETS);
            end
            else if (op_reg == bte_pkg::OP_CLEAR)
            begin
                meta_we = 1'b1;
                meta_wd = {listed_cur, {FW{1'b0}}};
            end
        end
        else if (state_reg == bte_pkg::S_PURGE_WR)
        begin
            meta_we = 1'b1;
            meta_wa = used_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
            meta_mem[meta_wa] <= meta_wd;
        meta_q <= meta_mem[meta_ra];
        if (ent_we)
            ent_mem[ent_wa] <= val_reg;
        ent_q <= ent_mem[ent_ra];
        if (used_we)
            used_mem[total_reg[BW-1:0]] <= key_reg;
        used_q <= used_mem[pidx_reg[BW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_vld_reg <= '0;
            meta_rv_reg  <= 1'b0;
        end
        else
        begin
            meta_rv_reg <= meta_vld_reg[meta_ra];
            if (meta_we)
                meta_vld_reg[meta_wa] <= 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bte_pkg::S_IDLE:
                if (start)
                begin
                    if (operation == bte_pkg::OP_PURGE)
                        state_next = bte_pkg::S_PURGE_RD;
                    else if (operation == bte_pkg::OP_CHECK)
                        state_next = bte_pkg::S_MOD;
                    else if (operation > bte_pkg::OP_CHECK)
                        state_next = bte_pkg::S_DONE;
                    else
                        state_next = bte_pkg::S_FILL_RD;
                end
            bte_pkg::S_MOD:
                if (bit_reg == VCW'(1))
                    state_next = bte_pkg::S_FILL_RD;
            bte_pkg::S_FILL_RD:   state_next = bte_pkg::S_FILL_WAIT;
            bte_pkg::S_FILL_WAIT:
                state_next = (op_reg == bte_pkg::OP_CHECK) ? bte_pkg::S_SCAN
                                                           : bte_pkg::S_EXEC;
            bte_pkg::S_EXEC:      state_next = bte_pkg::S_DONE;
            bte_pkg::S_SCAN:
                if ({1'b0, scan_reg} >= (DW+2)'(fill_reg) || hit_reg
                    || ent_q == val_reg)
                    state_next = bte_pkg::S_DONE;
            bte_pkg::S_PURGE_RD:
                state_next = (pidx_reg >= total_reg) ? bte_pkg::S_DONE
                                                     : bte_pkg::S_PURGE_WR;
            bte_pkg::S_PURGE_WR:  state_next = bte_pkg::S_PURGE_RD;
            bte_pkg::S_DONE:      state_next = bte_pkg::S_IDLE;
            default:              state_next = bte_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != bte_pkg::S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bte_pkg::S_IDLE;
            kc_reg     <= 9'd256;
            total_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (key_count_we)
                kc_reg <= key_count_wdata;
            if (used_we)
                total_reg <= total_reg + UW'(1);
            if (state_reg == bte_pkg::S_PURGE_RD && pidx_reg >= total_reg)
                total_reg <= '0;
            done_reg <= (state_reg == bte_pkg::S_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            bte_pkg::S_IDLE:
            begin
                op_reg     <= operation;
                key_reg    <= BW'(key);
                val_reg    <= value;
                idx_reg    <= index;
                krange_reg <= key_in_range;
                rem_reg    <= '0;
                bit_reg    <= VCW'(VALUE_BITS);
                pidx_reg   <= '0;
                hit_reg    <= 1'b0;
                scan_reg   <= '0;
                status_reg <= bte_pkg::ST_RANGE;
                count_reg  <= '0;
                ev_reg     <= '0;
                hitout_reg <= 1'b0;
                bucket_reg <= (operation < bte_pkg::OP_PURGE) ? key : 8'd0;
            end
            bte_pkg::S_MOD:
            begin
                rem_reg <= (rem_sh >= nb) ? rem_sh - nb : rem_sh;
                bit_reg <= bit_reg - VCW'(1);
                if (bit_reg == VCW'(1))
                    key_reg <= BW'((rem_sh >= nb) ? rem_sh - nb : rem_sh);
            end
            bte_pkg::S_FILL_WAIT:
            begin
                fill_reg   <= fill_cur;
                if (op_reg == bte_pkg::OP_CHECK)
                begin
                    status_reg <= bte_pkg::ST_OK;
                    count_reg  <= 4'(fill_cur);
                    bucket_reg <= 8'(key_reg);
                end
            end
            bte_pkg::S_EXEC:
            begin
                if (krange_reg)
                begin
                    status_reg <= bte_pkg::ST_OK;
                    count_reg  <= 4'(fill_cur);
                    case (op_reg)
                        bte_pkg::OP_ADD:
                            if (fill_cur >= FW'(BUCKET_DEPTH))
                                status_reg <= bte_pkg::ST_FULL;
                            else
                                count_reg <= 4'(fill_cur + FW'(1));
                        bte_pkg::OP_CLEAR:
                            count_reg <= '0;
                        bte_pkg::OP_READ:
                            if (8'(idx_reg) < 8'(fill_cur))
                                ev_reg <= ent_q;
                            else
                                status_reg <= bte_pkg::ST_RANGE;
                        default: ;
                    endcase
                end
            end
            bte_pkg::S_SCAN:
            begin
                if ({1'b0, scan_reg} < (DW+2)'(fill_reg) && ent_q == val_reg)
                begin
                    hit_reg    <= 1'b1;
                    hitout_reg <= 1'b1;
                end
                scan_reg <= scan_reg + (DW+1)'(1);
            end
            bte_pkg::S_PURGE_RD:
            begin
                if (pidx_reg >= total_reg)
                    status_reg <= bte_pkg::ST_OK;
                pidx_reg <= pidx_reg + UW'(1);
            end
            default: ;
        endcase
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign count       = count_reg;
    assign entry_value = ev_reg;
    assign hit         = hitout_reg;
    assign bucket      = bucket_reg;
    assign used_count  = 9'(total_reg);

endmodule
